>>> rtl/xte_pkg.sv
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types and text tables for the XML text escaper: the descriptor that
// travels from the classifier to the emitter, and the output unit lookup.
// ----------------------------------------------------------------------------
package xte_pkg;

  // What one accepted code unit expands into
  typedef enum logic [3:0] {
    K_CHAR = 4'd0,  // the unit itself
    K_PAIR = 4'd1,  // held high surrogate, then the low surrogate
    K_APOS = 4'd2,
    K_QUOT = 4'd3,
    K_AMP  = 4'd4,
    K_LT   = 4'd5,
    K_GT   = 4'd6,
    K_HEX  = 4'd7,  // &#xhhhh;
    K_MARK = 4'd8   // empty end-of-string marker
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] unit;
    logic [15:0] held;
    logic        last;
  } desc_t;

  typedef logic [0:7][7:0] text_t;

  localparam text_t TXT_APOS = {"&apos;", 16'h0000};
  localparam text_t TXT_QUOT = {"&quot;", 16'h0000};
  localparam text_t TXT_AMP  = {"&amp;",  24'h000000};
  localparam text_t TXT_LT   = {"&lt;",   32'h00000000};
  localparam text_t TXT_GT   = {"&gt;",   32'h00000000};
  localparam text_t TXT_HEX  = {"&#x",    8'h00, 8'h00, 8'h00, 8'h00, ";"};

  localparam logic [15:0] CU_APOS  = 16'h0027;
  localparam logic [15:0] CU_QUOT  = 16'h0022;
  localparam logic [15:0] CU_AMP   = 16'h0026;
  localparam logic [15:0] CU_LT    = 16'h003C;
  localparam logic [15:0] CU_GT    = 16'h003E;
  localparam logic [15:0] CU_TAB   = 16'h0009;
  localparam logic [15:0] CU_LF    = 16'h000A;
  localparam logic [15:0] CU_CR    = 16'h000D;
  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;
  localparam logic [15:0] NC_FFFE  = 16'hFFFE;
  localparam logic [15:0] NC_FFFF  = 16'hFFFF;

  // Index of the final output unit of a descriptor
  function automatic logic [2:0] kind_last_idx(input kind_t k);
    logic [2:0] r;
    unique case (k)
      K_CHAR:  r = 3'd0;
      K_PAIR:  r = 3'd1;
      K_APOS:  r = 3'd5;
      K_QUOT:  r = 3'd5;
      K_AMP:   r = 3'd4;
      K_LT:    r = 3'd3;
      K_GT:    r = 3'd3;
      K_HEX:   r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = {4'h3, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

  // Output unit number idx of descriptor d
  function automatic logic [15:0] unit_at(input desc_t d, input logic [2:0] idx);
    logic [15:0] r;
    logic [3:0]  nib;
    unique case (idx)
      3'd3:    nib = d.unit[15:12];
      3'd4:    nib = d.unit[11:8];
      3'd5:    nib = d.unit[7:4];
      default: nib = d.unit[3:0];
    endcase
    unique case (d.kind)
      K_CHAR:  r = d.unit;
      K_PAIR:  r = (idx == 3'd0) ? d.held : d.unit;
      K_APOS:  r = {8'h00, TXT_APOS[idx]};
      K_QUOT:  r = {8'h00, TXT_QUOT[idx]};
      K_AMP:   r = {8'h00, TXT_AMP[idx]};
      K_LT:    r = {8'h00, TXT_LT[idx]};
      K_GT:    r = {8'h00, TXT_GT[idx]};
      K_HEX: begin
        if (idx >= 3'd3 && idx <= 3'd6) begin
          r = {8'h00, hex_char(nib)};
        end else begin
          r = {8'h00, TXT_HEX[idx]};
        end
      end
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/xte_fifo.sv
// ----------------------------------------------------------------------------
// xte_fifo
// Short descriptor queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module xte_fifo
  import xte_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  nempty,
  output desc_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_MAX);
  assign nempty  = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> rtl/xte_front.sv
// ----------------------------------------------------------------------------
// xte_front
// Classifier: takes code units, tracks a held high surrogate and queues one
// descriptor for every unit that produces output, or an end marker for a closing unit.
// ----------------------------------------------------------------------------
module xte_front
  import xte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] code_unit,
  input  logic        last_in_string,
  output logic        q_push,
  output desc_t       q_desc
);

  logic [15:0] held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        is_high, is_low, is_nonchar, is_print, is_ctl_drop;
  kind_t       kind;
  logic        produces;

  assign is_high     = (code_unit >= HI_FIRST) && (code_unit <= HI_LAST);
  assign is_low      = (code_unit >= LO_FIRST) && (code_unit <= LO_LAST);
  assign is_nonchar  = (code_unit == NC_FFFE) || (code_unit == NC_FFFF);
  assign is_print    = ((code_unit >= 16'h0020) && (code_unit <= 16'h007E))
                     || (code_unit >= 16'h00A0);
  assign is_ctl_drop = (code_unit < 16'h0020) && (code_unit != CU_TAB)
                     && (code_unit != CU_LF) && (code_unit != CU_CR);

  always_comb begin
    kind     = K_MARK;
    produces = 1'b1;
    if (is_high) begin
      produces = 1'b0;
    end else if (held_valid_r && is_low) begin
      kind = K_PAIR;
    end else if (code_unit == CU_APOS) begin
      kind = K_APOS;
    end else if (code_unit == CU_QUOT) begin
      kind = K_QUOT;
    end else if (code_unit == CU_AMP) begin
      kind = K_AMP;
    end else if (code_unit == CU_LT) begin
      kind = K_LT;
    end else if (code_unit == CU_GT) begin
      kind = K_GT;
    end else if (is_low || is_nonchar || is_ctl_drop) begin
      produces = 1'b0;
    end else if (is_print) begin
      kind = K_CHAR;
    end else begin
      kind = K_HEX;
    end
  end

  // Nothing produced: queue an end marker only for the closing unit
  assign q_push      = accept && (produces || last_in_string);
  assign q_desc.kind = produces ? kind : K_MARK;
  assign q_desc.unit = code_unit;
  assign q_desc.held = held_r;
  assign q_desc.last = last_in_string;

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    if (accept) begin
      held_valid_nxt = is_high && !last_in_string;
      held_nxt       = code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

>>> rtl/xte_back.sv
// ----------------------------------------------------------------------------
// xte_back
// Emitter: steps through the head descriptor one output unit per cycle, while
// the result stage is free or being taken, into a registered result stage.
// ----------------------------------------------------------------------------
module xte_back
  import xte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nempty,
  input  desc_t       q_head,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [15:0] out_unit,
  output logic        has_char,
  output logic        last_of_run,
  output logic        end_of_string
);

  logic [2:0]  idx_r, idx_nxt;
  logic        ovld_r, ovld_nxt;
  logic [15:0] unit_r;
  logic        has_char_r, last_of_run_r, end_r;
  logic        load, fin;

  assign empty         = !ovld_r;
  assign out_unit      = unit_r;
  assign has_char      = has_char_r;
  assign last_of_run   = last_of_run_r;
  assign end_of_string = end_r;

  // Refill the result stage when it is free or being taken this cycle
  assign load  = q_nempty && (!ovld_r || pop);
  assign fin   = (idx_r == kind_last_idx(q_head.kind));
  assign q_pop = load && fin;

  always_comb begin
    idx_nxt  = idx_r;
    ovld_nxt = ovld_r;
    if (pop && ovld_r) begin
      ovld_nxt = 1'b0;
    end
    if (load) begin
      ovld_nxt = 1'b1;
      idx_nxt  = fin ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 3'd0;
      ovld_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r        <= unit_at(q_head, idx_r);
      has_char_r    <= (q_head.kind != K_MARK);
      last_of_run_r <= fin;
      end_r         <= fin && q_head.last;
    end
  end

endmodule

>>> rtl/xml_text_escaper.sv
// ----------------------------------------------------------------------------
// xml_text_escaper
// Streaming XML text escaper for UTF-16 code units.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_code_unit and in_last_in_string with in_push; a
//   transfer happens on a clock edge with in_push high and in_full low.
//   Result queue: while out_empty is low the oldest result sits on out_unit,
//   out_has_char, out_last_of_run and out_end_of_string; out_pop takes it.
//   Timing: an accepted code unit passes through the descriptor queue, then
//   the registered result stage. The classifier takes one unit per cycle
//   while in_full is low; the emitter produces one result per cycle while
//   out_pop keeps up, so plain characters run at one per cycle; entities (up
//   to eight results) occupy the emitter until their last. The descriptor
//   queue (FIFO_DEPTH entries) sets how long input flows before in_full rises.
//   Reset: rst_n low clears the queues, the emitter index and any held high
//   surrogate; both queues come out empty.
//   Stall: with out_pop low the result stage holds its value, the descriptor
//   queue fills and then in_full holds the sender off. Nothing is dropped.
// ----------------------------------------------------------------------------
module xml_text_escaper
  import xte_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_in_string,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_unit,
  output logic        out_has_char,
  output logic        out_last_of_run,
  output logic        out_end_of_string
);

  logic  in_accept;
  logic  q_push, q_pop, q_full, q_nempty;
  desc_t q_desc, q_head;

  // The input side only stalls when the descriptor queue is full
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // Classify, track the held surrogate and queue a descriptor
  xte_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .code_unit      (in_code_unit),
    .last_in_string (in_last_in_string),
    .q_push         (q_push),
    .q_desc         (q_desc)
  );

  // Decouple classification from emission
  xte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .nempty    (q_nempty),
    .head      (q_head)
  );

  // Expand each descriptor into its output units, one per cycle while the result stage is free or being taken
  xte_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nempty      (q_nempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .pop           (out_pop),
    .empty         (out_empty),
    .out_unit      (out_unit),
    .has_char      (out_has_char),
    .last_of_run   (out_last_of_run),
    .end_of_string (out_end_of_string)
  );

`ifndef NO_ASSERTIONS
  // End of string only ever closes a run
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_end_of_string) |-> out_last_of_run)
    else $error("end_of_string without last_of_run");

  // The empty marker is a lone, zero, end-of-string result
  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_has_char) |->
      (out_unit == 16'h0000 && out_last_of_run && out_end_of_string))
    else $error("malformed end marker");

  // Reset leaves the result queue empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
`endif

endmodule
